@@ hdl/pdtf_pkg.sv @@
// Shared types, constants and the quarter-wave sine table for the pixel to tool-frame converter.
package pdtf_pkg;

   localparam int DEF_PIXEL_BITS = 12;
   localparam int DEF_DEPTH_BITS = 16;
   localparam int DEF_TRIG_BITS  = 16;

   localparam int COORD_W = 24;
   localparam int RATIO_W = 16;
   localparam int CSR_W   = 24;
   localparam int TABLE_W = 16;

   localparam int COORD_MAX = 8388607;
   localparam int COORD_MIN = -8388608;

   localparam logic signed [17:0] ROT_SMALL = 18'sd16961;
   localparam logic signed [17:0] ROT_LARGE = 18'sd63301;

   localparam logic [RATIO_W-1:0]        H_RATIO_RST = 16'd2908;
   localparam logic [RATIO_W-1:0]        V_RATIO_RST = 16'd3520;
   localparam logic signed [COORD_W-1:0] OFF_FWD_RST = 24'sd27840;
   localparam logic signed [COORD_W-1:0] OFF_UP_RST  = -24'sd19891;

   typedef enum logic [1:0] {
      CSR_H_RATIO = 2'd0,
      CSR_V_RATIO = 2'd1,
      CSR_OFF_FWD = 2'd2,
      CSR_OFF_UP  = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic                neg;
      logic [TABLE_W-1:0]  mag;
   } trig_fold_type;

   localparam logic [TABLE_W-1:0] QSINE [0:90] = '{
      16'd0, 16'd572, 16'd1144, 16'd1715, 16'd2286, 16'd2856, 16'd3425, 16'd3993,
      16'd4560, 16'd5126, 16'd5690, 16'd6252, 16'd6813, 16'd7371, 16'd7927, 16'd8481,
      16'd9032, 16'd9580, 16'd10126, 16'd10668, 16'd11207, 16'd11743, 16'd12275,
      16'd12803, 16'd13328, 16'd13848, 16'd14365, 16'd14876, 16'd15384, 16'd15886,
      16'd16384, 16'd16877, 16'd17364, 16'd17847, 16'd18324, 16'd18795, 16'd19261,
      16'd19720, 16'd20174, 16'd20622, 16'd21063, 16'd21498, 16'd21926, 16'd22348,
      16'd22763, 16'd23170, 16'd23571, 16'd23965, 16'd24351, 16'd24730, 16'd25102,
      16'd25466, 16'd25822, 16'd26170, 16'd26510, 16'd26842, 16'd27166, 16'd27482,
      16'd27789, 16'd28088, 16'd28378, 16'd28660, 16'd28932, 16'd29197, 16'd29452,
      16'd29698, 16'd29935, 16'd30163, 16'd30382, 16'd30592, 16'd30792, 16'd30983,
      16'd31164, 16'd31336, 16'd31499, 16'd31651, 16'd31795, 16'd31928, 16'd32052,
      16'd32166, 16'd32270, 16'd32365, 16'd32449, 16'd32524, 16'd32588, 16'd32643,
      16'd32688, 16'd32723, 16'd32748, 16'd32763, 16'd32768
   };

   function automatic trig_fold_type sine_fold(input logic [8:0] deg);
      trig_fold_type res;
      logic [8:0]    idx;
      res.neg = 1'b0;
      if (deg <= 9'd90) begin
         idx = deg;
      end else if (deg <= 9'd180) begin
         idx = 9'd180 - deg;
      end else if (deg <= 9'd270) begin
         idx     = deg - 9'd180;
         res.neg = 1'b1;
      end else begin
         idx     = 9'd360 - deg;
         res.neg = 1'b1;
      end
      res.mag = QSINE[idx[6:0]];
      return res;
   endfunction

endpackage

@@ hdl/pixel_depth_to_tool_frame.sv @@
// Pixel offset and depth to tool-frame point converter, seven-stage pipeline.
//
//   port group   dir   handshake            payload
//   req_         in    req_valid/req_ready  pixel_dx, pixel_dy, depth
//   rsp_         out   rsp_valid/rsp_ready  coord_a, coord_b, coord_c, saturated
//   csr_         in    csr_valid/csr_ready  csr_index, csr_wdata
//
// One transaction per cycle while the response side accepts; rsp_ready backpressure can stall requests.
// Stages: ratio multiply, degree reduction, sine table, range multiply,
// elevation multiply, rotation multiply, offset add with round and clip.
// Each stage holds only while it is full and the stage after it holds, so
// bubbles close up under response backpressure. Synchronous reset empties the
// pipeline and restores the register defaults; csr_ready is always high.
module pixel_depth_to_tool_frame
   import pdtf_pkg::*;
#(
   parameter int PIXEL_BITS = DEF_PIXEL_BITS,
   parameter int DEPTH_BITS = DEF_DEPTH_BITS,
   parameter int TRIG_BITS  = DEF_TRIG_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [PIXEL_BITS-1:0] req_pixel_dx,
   input  logic signed [PIXEL_BITS-1:0] req_pixel_dy,
   input  logic        [DEPTH_BITS-1:0] req_depth,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [COORD_W-1:0]    rsp_coord_a,
   output logic signed [COORD_W-1:0]    rsp_coord_b,
   output logic signed [COORD_W-1:0]    rsp_coord_c,
   output logic                         rsp_saturated,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [1:0]                   csr_index,
   input  logic [CSR_W-1:0]             csr_wdata
);

   localparam int NST    = 7;
   localparam int PW     = PIXEL_BITS + RATIO_W + 1;
   localparam int QB     = PIXEL_BITS - 1;
   localparam int TB     = TRIG_BITS;
   localparam int TS     = TB + 1;
   localparam int F      = TB - 1;
   localparam int UP     = (TB > TABLE_W) ? TB - TABLE_W : 0;
   localparam int DN     = (TB < TABLE_W) ? TABLE_W - TB : 0;
   localparam int HALFDN = (DN > 0) ? (1 << (DN - 1)) : 0;
   localparam int TW     = TABLE_W + 1 + UP;
   localparam int SH4    = F - 4;
   localparam int HALF4  = 1 << (SH4 - 1);
   localparam int HALFF  = 1 << (F - 1);
   localparam int SW     = DEPTH_BITS + 5;
   localparam int P4W    = DEPTH_BITS + 1 + TS;
   localparam int P5W    = SW + TS;
   localparam int PPW    = SW + 18;
   localparam int AW     = (PPW + 2 > 42) ? PPW + 2 : 42;
   localparam int VW     = AW - 16;
   localparam int HALF16 = 1 << 15;

   function automatic logic [8:0] whole_deg(input logic signed [PW-1:0] p);
      logic [PW-1:0] m;
      logic [QB-1:0] rq;
      logic [8:0]    rem;
      m  = p[PW-1] ? PW'(-p) : PW'(p);
      rq = m[16 +: QB];
      for (int k = QB - 9; k >= 0; k--) begin
         if (rq >= QB'(360 << k)) begin
            rq = rq - QB'(360 << k);
         end
      end
      rem = 9'(rq);
      return (p[PW-1] && rem != 9'd0) ? 9'd360 - rem : rem;
   endfunction

   function automatic logic signed [TS-1:0] trig_val(input trig_fold_type f);
      logic [TW-1:0] wide;
      logic [TB-1:0] mag;
      wide = (TW'(f.mag) + TW'(HALFDN)) << UP;
      mag  = TB'(wide >> DN);
      return f.neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
   endfunction

   function automatic logic [COORD_W:0] clip_coord(input logic signed [VW-1:0] v);
      if (v > $signed(VW'(COORD_MAX))) begin
         return {1'b1, COORD_W'(COORD_MAX)};
      end else if (v < $signed(VW'(COORD_MIN))) begin
         return {1'b1, COORD_W'(COORD_MIN)};
      end
      return {1'b0, COORD_W'(v)};
   endfunction

   // configuration registers
   logic [RATIO_W-1:0]        h_ratio_ff;
   logic [RATIO_W-1:0]        v_ratio_ff;
   logic signed [COORD_W-1:0] off_fwd_ff;
   logic signed [COORD_W-1:0] off_up_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         h_ratio_ff <= H_RATIO_RST;
         v_ratio_ff <= V_RATIO_RST;
         off_fwd_ff <= OFF_FWD_RST;
         off_up_ff  <= OFF_UP_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_H_RATIO: h_ratio_ff <= csr_wdata[RATIO_W-1:0];
            CSR_V_RATIO: v_ratio_ff <= csr_wdata[RATIO_W-1:0];
            CSR_OFF_FWD: off_fwd_ff <= csr_wdata;
            CSR_OFF_UP:  off_up_ff  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // pipeline control
   logic [NST:1] v_ff;
   logic [NST:1] v_in;
   logic [NST:1] en;

   always_comb begin
      en[NST] = !v_ff[NST] || rsp_ready;
      for (int k = NST - 1; k >= 1; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
      v_in[1] = en[1] ? req_valid : v_ff[1];
      for (int k = 2; k <= NST; k++) begin
         v_in[k] = en[k] ? v_ff[k-1] : v_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign req_ready = en[1];
   assign rsp_valid = v_ff[NST];

   // stage 1: pixel times ratio
   logic signed [PW-1:0]   pth1_ff, pth1_in, pph1_ff, pph1_in;
   logic [DEPTH_BITS-1:0]  r1_ff;

   always_comb begin
      pth1_in = PW'(req_pixel_dx) * PW'($signed({1'b0, h_ratio_ff}));
      pph1_in = PW'(req_pixel_dy) * PW'($signed({1'b0, v_ratio_ff}));
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         pth1_ff <= pth1_in;
         pph1_ff <= pph1_in;
         r1_ff   <= req_depth;
      end
   end

   // stage 2: whole degrees, reduced to 0..359
   logic [8:0]            th2_ff, th2_in, ph2_ff, ph2_in;
   logic [DEPTH_BITS-1:0] r2_ff;

   always_comb begin
      th2_in = whole_deg(pth1_ff);
      ph2_in = whole_deg(pph1_ff);
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         th2_ff <= th2_in;
         ph2_ff <= ph2_in;
         r2_ff  <= r1_ff;
      end
   end

   // stage 3: sine and cosine lookup
   logic signed [TS-1:0]  st3_ff, st3_in, ct3_ff, ct3_in;
   logic signed [TS-1:0]  sp3_ff, sp3_in, cp3_ff, cp3_in;
   logic [DEPTH_BITS-1:0] r3_ff;
   logic [8:0]            thc, phc;

   always_comb begin
      thc = th2_ff + 9'd90;
      if (thc >= 9'd360) begin
         thc = thc - 9'd360;
      end
      phc = ph2_ff + 9'd90;
      if (phc >= 9'd360) begin
         phc = phc - 9'd360;
      end
      st3_in = trig_val(sine_fold(th2_ff));
      ct3_in = trig_val(sine_fold(thc));
      sp3_in = trig_val(sine_fold(ph2_ff));
      cp3_in = trig_val(sine_fold(phc));
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         st3_ff <= st3_in;
         ct3_ff <= ct3_in;
         sp3_ff <= sp3_in;
         cp3_ff <= cp3_in;
         r3_ff  <= r2_ff;
      end
   end

   // stage 4: s = r sin(theta), z = r cos(theta)
   logic signed [P4W-1:0] ps4, pz4, rs4, rz4;
   logic signed [SW-1:0]  s4_ff, s4_in, z4_ff, z4_in;
   logic signed [TS-1:0]  sp4_ff, cp4_ff;

   always_comb begin
      ps4   = P4W'($signed({1'b0, r3_ff})) * P4W'(st3_ff);
      pz4   = P4W'($signed({1'b0, r3_ff})) * P4W'(ct3_ff);
      rs4   = ps4 + $signed(P4W'(HALF4)) - $signed(P4W'(ps4[P4W-1]));
      rz4   = pz4 + $signed(P4W'(HALF4)) - $signed(P4W'(pz4[P4W-1]));
      s4_in = SW'(rs4 >>> SH4);
      z4_in = SW'(rz4 >>> SH4);
   end

   always_ff @(posedge clock) begin
      if (en[4]) begin
         s4_ff  <= s4_in;
         z4_ff  <= z4_in;
         sp4_ff <= sp3_ff;
         cp4_ff <= cp3_ff;
      end
   end

   // stage 5: x = s cos(phi), y = s sin(phi)
   logic signed [P5W-1:0] px5, py5, rx5, ry5;
   logic signed [SW-1:0]  x5_ff, x5_in, y5_ff, y5_in, z5_ff;

   always_comb begin
      px5   = P5W'(s4_ff) * P5W'(cp4_ff);
      py5   = P5W'(s4_ff) * P5W'(sp4_ff);
      rx5   = px5 + $signed(P5W'(HALFF)) - $signed(P5W'(px5[P5W-1]));
      ry5   = py5 + $signed(P5W'(HALFF)) - $signed(P5W'(py5[P5W-1]));
      x5_in = SW'(rx5 >>> F);
      y5_in = SW'(ry5 >>> F);
   end

   always_ff @(posedge clock) begin
      if (en[5]) begin
         x5_ff <= x5_in;
         y5_ff <= y5_in;
         z5_ff <= z4_ff;
      end
   end

   // stage 6: rotation products
   logic signed [PPW-1:0] ya6_ff, ya6_in, za6_ff, za6_in;
   logic signed [PPW-1:0] yc6_ff, yc6_in, zc6_ff, zc6_in;
   logic signed [SW-1:0]  x6_ff;

   always_comb begin
      ya6_in = PPW'(ROT_SMALL) * PPW'(y5_ff);
      za6_in = PPW'(ROT_LARGE) * PPW'(z5_ff);
      yc6_in = PPW'(ROT_LARGE) * PPW'(y5_ff);
      zc6_in = PPW'(ROT_SMALL) * PPW'(z5_ff);
   end

   always_ff @(posedge clock) begin
      if (en[6]) begin
         ya6_ff <= ya6_in;
         za6_ff <= za6_in;
         yc6_ff <= yc6_in;
         zc6_ff <= zc6_in;
         x6_ff  <= x5_ff;
      end
   end

   // stage 7: add offsets, round, clip
   logic signed [AW-1:0]      ya7, za7, yc7, zc7, offf7, offu7, suma7, sumc7, rnda7, rndc7;
   logic signed [VW-1:0]      va7, vc7, vx7;
   logic [COORD_W:0]          ca7, cb7, cc7;
   logic signed [COORD_W-1:0] coord_a_ff, coord_b_ff, coord_c_ff;
   logic                      sat_ff, sat_in;

   always_comb begin
      ya7    = AW'(ya6_ff);
      za7    = AW'(za6_ff);
      yc7    = AW'(yc6_ff);
      zc7    = AW'(zc6_ff);
      offf7  = AW'(off_fwd_ff);
      offu7  = AW'(off_up_ff);
      suma7  = ya7 + za7 + (offf7 <<< 16);
      sumc7  = yc7 - zc7 + (offu7 <<< 16);
      rnda7  = suma7 + $signed(AW'(HALF16)) - $signed(AW'(suma7[AW-1]));
      rndc7  = sumc7 + $signed(AW'(HALF16)) - $signed(AW'(sumc7[AW-1]));
      va7    = VW'(rnda7 >>> 16);
      vc7    = VW'(rndc7 >>> 16);
      vx7    = VW'(x6_ff);
      ca7    = clip_coord(va7);
      cb7    = clip_coord(vx7);
      cc7    = clip_coord(vc7);
      sat_in = ca7[COORD_W] || cb7[COORD_W] || cc7[COORD_W];
   end

   always_ff @(posedge clock) begin
      if (en[7]) begin
         coord_a_ff <= ca7[COORD_W-1:0];
         coord_b_ff <= cb7[COORD_W-1:0];
         coord_c_ff <= cc7[COORD_W-1:0];
         sat_ff     <= sat_in;
      end
   end

   assign rsp_coord_a   = coord_a_ff;
   assign rsp_coord_b   = coord_b_ff;
   assign rsp_coord_c   = coord_c_ff;
   assign rsp_saturated = sat_ff;

   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> v_ff[1])
      else $error("accepted transaction did not enter the pipeline");

   a_deg_range: assert property (@(posedge clock) disable iff (reset)
      v_ff[2] |-> (th2_ff < 9'd360 && ph2_ff < 9'd360))
      else $error("reduced angle out of range");

   a_trig_range: assert property (@(posedge clock) disable iff (reset)
      v_ff[3] |-> (st3_ff <= $signed(TS'(1 << F)) && st3_ff >= -$signed(TS'(1 << F)) &&
                   cp3_ff <= $signed(TS'(1 << F)) && cp3_ff >= -$signed(TS'(1 << F))))
      else $error("trig value exceeds unity");

   a_sat_at_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_saturated) |->
         (rsp_coord_a == COORD_W'(COORD_MAX) || rsp_coord_a == COORD_W'(COORD_MIN) ||
          rsp_coord_b == COORD_W'(COORD_MAX) || rsp_coord_b == COORD_W'(COORD_MIN) ||
          rsp_coord_c == COORD_W'(COORD_MAX) || rsp_coord_c == COORD_W'(COORD_MIN)))
      else $error("saturated flag without a clipped coordinate");

endmodule
